FILE: src/mdcl_pkg.sv
// Shared types and constants for the incremental MPC duty-cycle control law.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mdcl_pkg;

  localparam int StateN   = 5;   // extended-state elements per item
  localparam int StateW   = 16;  // state and reference width, LSB 1/64
  localparam int GainW    = 32;  // Q16.16 gain width
  localparam int ProdW    = GainW + StateW;  // exact product, LSB 2^-22
  localparam int SumW     = ProdW + 3;       // six products plus held duty
  localparam int DutyW    = 16;  // duty width, LSB 2^-16
  localparam int FracSh   = 6;   // 2^-22 to 2^-16
  localparam int DutyMax  = 32768;  // 0.5
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegGain0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGain1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGain2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGain3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGain4 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegKy    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRef   = 3'd6;

  localparam logic [StateW-1:0] RefReset = 16'd1600;

  localparam logic signed [SumW-1:0] TotalMax   = SumW'(DutyMax * (2 ** FracSh));
  localparam logic signed [SumW-1:0] RoundHalf  = SumW'(2 ** (FracSh - 1));
  localparam logic [DutyW-1:0]       DutyMaxVal = DutyW'(DutyMax);

  typedef logic [StateN-1:0][StateW-1:0] states_t;
  // Products: index 0..4 state terms, index StateN the reference term
  typedef logic [StateN:0][ProdW-1:0]    prod_t;
  typedef logic [1:0][SumW-1:0]          part_t;

  typedef struct packed {
    logic [StateN-1:0][GainW-1:0] gain;
    logic [GainW-1:0]             ky_gain;
    logic [StateW-1:0]            reference;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/mdcl_intf.sv
// Valid/ready channel interfaces for state items in and duty items out.
// Depends on mdcl_pkg for field widths.
`default_nettype none

interface mdcl_state_if;
  import mdcl_pkg::*;
  logic              valid;
  logic              ready;
  logic [StateW-1:0] state_0;
  logic [StateW-1:0] state_1;
  logic [StateW-1:0] state_2;
  logic [StateW-1:0] state_3;
  logic [StateW-1:0] state_4;

  modport source (output valid, state_0, state_1, state_2, state_3, state_4, input ready);
  modport sink   (input valid, state_0, state_1, state_2, state_3, state_4, output ready);
endinterface

interface mdcl_duty_if;
  import mdcl_pkg::*;
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty_cycle;

  modport source (output valid, duty_cycle, input ready);
  modport sink   (input valid, duty_cycle, output ready);
endinterface

`default_nettype wire

FILE: src/mdcl_cfg_regs.sv
// Gain and setpoint registers written through the plain configuration port.
// Depends on mdcl_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module mdcl_cfg_regs import mdcl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain      <= '0;
      cfg_q.ky_gain   <= '0;
      cfg_q.reference <= RefReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGain0: cfg_q.gain[0]    <= cfg_wdata_i[GainW-1:0];
        RegGain1: cfg_q.gain[1]    <= cfg_wdata_i[GainW-1:0];
        RegGain2: cfg_q.gain[2]    <= cfg_wdata_i[GainW-1:0];
        RegGain3: cfg_q.gain[3]    <= cfg_wdata_i[GainW-1:0];
        RegGain4: cfg_q.gain[4]    <= cfg_wdata_i[GainW-1:0];
        RegKy:    cfg_q.ky_gain    <= cfg_wdata_i[GainW-1:0];
        RegRef:   cfg_q.reference  <= cfg_wdata_i[StateW-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/mdcl_mult_stage.sv
// Product stage: six parallel gain-times-sample products, exact at LSB 2^-22.
// Depends on mdcl_pkg.
`default_nettype none

module mdcl_mult_stage import mdcl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    ld_i,
  input  wire states_t states_i,
  input  wire cfg_t    cfg_i,
  output prod_t        prod_o
);

  prod_t prod_d;
  prod_t prod_q;

  always_comb begin
    for (int i = 0; i < StateN; i++) begin
      prod_d[i] = $signed(cfg_i.gain[i]) * $signed(states_i[i]);
    end
    prod_d[StateN] = $signed(cfg_i.ky_gain) * $signed(cfg_i.reference);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: src/mdcl_sum_stage.sv
// Partial sum stage: folds the six products into two signed partial sums.
// Depends on mdcl_pkg.
`default_nettype none

module mdcl_sum_stage import mdcl_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  ld_i,
  input  wire prod_t prod_i,
  output part_t      part_o
);

  logic signed [SumW-1:0] term [StateN+1];
  part_t part_d;
  part_t part_q;

  always_comb begin
    for (int i = 0; i <= StateN; i++) begin
      term[i] = SumW'(signed'(prod_i[i]));
    end
    // reference term minus the first two feedback terms, then the rest
    part_d[0] = term[StateN] - term[0] - term[1];
    part_d[1] = -(term[2] + term[3] + term[4]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      part_q <= part_d;
    end
  end

  assign part_o = part_q;

endmodule

`default_nettype wire

FILE: src/mdcl_duty_stage.sv
// Duty stage: adds the held duty, clamps to 0..0.5, rounds to LSB 2^-16.
// The result register doubles as the held duty. Depends on mdcl_pkg.
`default_nettype none

module mdcl_duty_stage import mdcl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        ld_i,
  input  wire part_t       part_i,
  output logic [DutyW-1:0] duty_o
);

  logic [DutyW-1:0]       duty_q;
  logic [DutyW-1:0]       duty_d;
  logic signed [SumW-1:0] held;
  logic signed [SumW-1:0] total;
  logic signed [SumW-1:0] rnd;

  always_comb begin
    held  = SumW'({duty_q, {FracSh{1'b0}}});
    total = held + $signed(part_i[0]) + $signed(part_i[1]);
    rnd   = total + RoundHalf;
    if (total <= 0) begin
      duty_d = '0;
    end else if (total >= TotalMax) begin
      duty_d = DutyMaxVal;
    end else begin
      duty_d = rnd[FracSh +: DutyW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
    end else if (ld_i) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o = duty_q;

endmodule

`default_nettype wire

FILE: src/mpc_duty_control_law.sv
// Top level of the incremental MPC duty-cycle control law.
// Depends on mdcl_pkg, the channel interfaces and the stage modules.
//
// Each state item yields one duty item, carried through an input register,
// a product register, a partial-sum register and the duty register, each
// parted by one multiply, a short add or the final add-clamp-round. The
// pipeline takes one item per cycle while the output is not stalled; the only
// loop is the held duty, which closes inside the last stage. Stages advance on
// their own, so a waiting result still lets earlier stages fill. Gains and the
// setpoint must be written by the user while no item is in flight; the block
// itself does not enforce this.
`default_nettype none

module mpc_duty_control_law import mdcl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  mdcl_state_if.sink               state_i,
  mdcl_duty_if.source              duty_o
);

  cfg_t    cfg;
  states_t states_q;
  prod_t   prod;
  part_t   part;

  logic in_v_q, prod_v_q, part_v_q, out_v_q;
  logic ld_in, ld_prod, ld_part, ld_out;

  // load chain, computed back from the output
  assign ld_out  = part_v_q && (!out_v_q || duty_o.ready);
  assign ld_part = prod_v_q && (!part_v_q || ld_out);
  assign ld_prod = in_v_q && (!prod_v_q || ld_part);
  assign state_i.ready = !in_v_q || ld_prod;
  assign ld_in   = state_i.valid && state_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      part_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (ld_in) begin
        in_v_q <= 1'b1;
      end else if (ld_prod) begin
        in_v_q <= 1'b0;
      end
      if (ld_prod) begin
        prod_v_q <= 1'b1;
      end else if (ld_part) begin
        prod_v_q <= 1'b0;
      end
      if (ld_part) begin
        part_v_q <= 1'b1;
      end else if (ld_out) begin
        part_v_q <= 1'b0;
      end
      if (ld_out) begin
        out_v_q <= 1'b1;
      end else if (duty_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      states_q <= {state_i.state_4, state_i.state_3, state_i.state_2,
                   state_i.state_1, state_i.state_0};
    end
  end

  mdcl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mdcl_mult_stage u_mult (
    .clk_i    (clk_i),
    .ld_i     (ld_prod),
    .states_i (states_q),
    .cfg_i    (cfg),
    .prod_o   (prod)
  );

  mdcl_sum_stage u_sum (
    .clk_i  (clk_i),
    .ld_i   (ld_part),
    .prod_i (prod),
    .part_o (part)
  );

  mdcl_duty_stage u_duty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld_out),
    .part_i (part),
    .duty_o (duty_o.duty_cycle)
  );

  assign duty_o.valid = out_v_q;

endmodule

`default_nettype wire

FILE: src/mdcl_checker.sv
// Port-level checks for mpc_duty_control_law, attached by the bind below.
// Depends on mdcl_pkg for the duty limit.
`default_nettype none

module mdcl_checker import mdcl_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [DutyW-1:0] duty_i
);

  // duty never leaves the clamp range
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> duty_i <= DutyMaxVal)
    else $error("duty above 0.5");

  // with the output free to drain, the pipeline always takes an item
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while output drains");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(duty_i))
    else $error("stalled duty item changed");

  // an item arriving into an idle block with output drained is never refused
  a_in_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !out_valid_i |-> in_ready_i)
    else $error("item refused with empty output");

endmodule

bind mpc_duty_control_law mdcl_checker u_mdcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (state_i.valid),
  .in_ready_i  (state_i.ready),
  .out_valid_i (duty_o.valid),
  .out_ready_i (duty_o.ready),
  .duty_i      (duty_o.duty_cycle)
);

`default_nettype wire
